### rtl/prewitt_laplacian_3x3_filter_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Prewitt / Laplacian 3x3 filter
// Shared property forms used by the filter's checker. Each macro expects
// signals named clk and rst_n in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef PREWITT_LAPLACIAN_3X3_FILTER_ASSERT_SVH
`define PREWITT_LAPLACIAN_3X3_FILTER_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define PLF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define PLF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/plf_pkg.sv
// ----------------------------------------------------------------------------
// plf_pkg
// Types, widths and constants shared by the Prewitt / Laplacian 3x3 filter.
// ----------------------------------------------------------------------------
`default_nettype none

package plf_pkg;

  // Field widths
  localparam int PIX_W      = 8;
  localparam int RES_W      = 11;
  localparam int FW_W       = 9;   // frame_width register
  localparam int FH_W       = 11;  // frame_height register
  localparam int ROW_W      = 11;
  localparam int EMIT_W     = 18;
  localparam int TOTAL_W    = FW_W + FH_W;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;

  // Register reset values and limits
  localparam int MAX_WIDTH_DEF = 256;
  localparam int WIDTH_RST     = 176;
  localparam int HEIGHT_RST    = 144;
  localparam int MIN_DIM       = 3;
  localparam int HEIGHT_LIMIT  = 1024;

  // Laplacian centre weight is -4: subtract the centre shifted left by two
  localparam int LAP_SHIFT = 2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

  // Item kinds
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  typedef logic [PIX_W-1:0]        pix_t;
  typedef logic signed [RES_W-1:0] res_t;

  // One window column, index 0 = top row, 2 = bottom row
  typedef logic [2:0][PIX_W-1:0] col3_t;

  // Border control for the kernel
  typedef struct packed {
    logic col_first;   // new column is the first column: result at the right border, right column padded
    logic col_second;  // left window column lies outside the frame
  } kern_ctl_t;

  typedef struct packed {
    res_t vert;
    res_t horiz;
    res_t lap;
  } kern_res_t;

endpackage

`default_nettype wire

### rtl/plf_ram.sv
// ----------------------------------------------------------------------------
// plf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module plf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/plf_kernel.sv
// ----------------------------------------------------------------------------
// plf_kernel
// 3x3 window arithmetic: vertical and horizontal Prewitt gradients and the
// 4-neighbour Laplacian, with zero padding at the left and right borders.
// ----------------------------------------------------------------------------
`default_nettype none

module plf_kernel (
  input  plf_pkg::col3_t     win_left,
  input  plf_pkg::col3_t     win_mid,
  input  plf_pkg::col3_t     new_col,
  input  plf_pkg::kern_ctl_t ctl,
  output plf_pkg::kern_res_t res
);
  import plf_pkg::*;

  localparam int SUM_W = PIX_W + 2;

  col3_t            l_col;
  col3_t            r_col;
  logic [SUM_W-1:0] sum_left;
  logic [SUM_W-1:0] sum_right;
  logic [SUM_W-1:0] sum_top;
  logic [SUM_W-1:0] sum_bottom;
  logic [SUM_W-1:0] sum_edge;
  logic [SUM_W-1:0] centre_x4;

  // Pad columns that fall outside the frame
  always_comb begin
    l_col = ctl.col_second ? '0 : win_left;
    r_col = ctl.col_first  ? '0 : new_col;
  end

  // Column, row and neighbour sums
  always_comb begin
    sum_left   = SUM_W'(l_col[0]) + SUM_W'(l_col[1]) + SUM_W'(l_col[2]);
    sum_right  = SUM_W'(r_col[0]) + SUM_W'(r_col[1]) + SUM_W'(r_col[2]);
    sum_top    = SUM_W'(l_col[0]) + SUM_W'(win_mid[0]) + SUM_W'(r_col[0]);
    sum_bottom = SUM_W'(l_col[2]) + SUM_W'(win_mid[2]) + SUM_W'(r_col[2]);
    sum_edge   = SUM_W'(win_mid[0]) + SUM_W'(l_col[1]) + SUM_W'(r_col[1])
               + SUM_W'(win_mid[2]);
    centre_x4  = SUM_W'(win_mid[1]) << LAP_SHIFT;
  end

  // Signed differences
  always_comb begin
    res.vert  = RES_W'($signed({1'b0, sum_left})   - $signed({1'b0, sum_right}));
    res.horiz = RES_W'($signed({1'b0, sum_bottom}) - $signed({1'b0, sum_top}));
    res.lap   = RES_W'($signed({1'b0, sum_edge})   - $signed({1'b0, centre_x4}));
  end

endmodule

`default_nettype wire

### rtl/prewitt_laplacian_3x3_filter.sv
// ----------------------------------------------------------------------------
// prewitt_laplacian_3x3_filter
// Streaming 3x3 Prewitt and Laplacian filter over 8-bit luma in raster order,
// zero padded outside the frame, with two line stores.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+------------------------------
//   cfg     | in        | cfg_we                 | cfg_idx, cfg_wdata
//   in      | in        | in_valid / in_ready    | in_op, in_pixel
//   out     | out       | out_valid / out_ready  | out_vert_gradient,
//           |           |                        | out_horiz_gradient,
//           |           |                        | out_laplacian, out_last_of_frame
//
// One item per clock while the output is not stalled. An item waits in the stage
// register, where the line store read data arrives, and its result is loaded into
// the output register as it leaves. The first result of a frame comes from item
// frame_width + 1, counting from zero. Reset clears the counters, window and valid
// flags; the line stores are not cleared. A stalled output holds an occupied stage register and drops in_ready.
// ----------------------------------------------------------------------------
`default_nettype none

module prewitt_laplacian_3x3_filter #(
  parameter int MAX_WIDTH = plf_pkg::MAX_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [plf_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [plf_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_op,
  input  logic [plf_pkg::PIX_W-1:0]          in_pixel,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [plf_pkg::RES_W-1:0]   out_vert_gradient,
  output logic signed [plf_pkg::RES_W-1:0]   out_horiz_gradient,
  output logic signed [plf_pkg::RES_W-1:0]   out_laplacian,
  output logic                               out_last_of_frame
);
  import plf_pkg::*;

  localparam int ADDR_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CMP_W  = (ADDR_W > FW_W) ? ADDR_W : FW_W;

  // Configuration
  logic [FW_W-1:0]    frame_width_r;
  logic [FH_W-1:0]    frame_height_r;
  logic [FW_W-1:0]    w_eff;
  logic [FH_W-1:0]    h_eff;
  logic [TOTAL_W-1:0] total;

  // Stage register
  logic               s1_valid_r;
  logic               s1_op_r;
  pix_t               s1_pixel_r;
  logic               s1_fire;
  logic               in_xfer;

  // Position and window state
  logic [ADDR_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic [EMIT_W-1:0]  emit_cnt_r, emit_cnt_nxt;
  col3_t              win_a_r, win_a_nxt;
  col3_t              win_b_r, win_b_nxt;

  logic [ADDR_W-1:0]  c_cur;
  logic [CMP_W-1:0]   c_inc;
  logic               c_wrap;
  logic [ADDR_W-1:0]  c_next_rd;
  logic [ADDR_W-1:0]  rd_addr;
  pix_t               up_rdata;
  pix_t               mid_rdata;
  col3_t              ncol;
  logic               emit;
  logic               last;
  kern_ctl_t          kctl;
  kern_res_t          kres;

  // Output register
  logic               out_valid_r, out_valid_nxt;
  res_t               out_vert_r, out_horiz_r, out_lap_r;
  logic               out_last_r;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FW_W'(WIDTH_RST);
      frame_height_r <= FH_W'(HEIGHT_RST);
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata[FW_W-1:0];
        REG_FRAME_HEIGHT: frame_height_r <= cfg_wdata[FH_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp frame size and form the pixel count
  always_comb begin
    if (int'(frame_width_r) < MIN_DIM) begin
      w_eff = FW_W'(MIN_DIM);
    end else if (int'(frame_width_r) > MAX_WIDTH) begin
      w_eff = FW_W'(MAX_WIDTH);
    end else begin
      w_eff = frame_width_r;
    end
    if (int'(frame_height_r) < MIN_DIM) begin
      h_eff = FH_W'(MIN_DIM);
    end else if (int'(frame_height_r) > HEIGHT_LIMIT) begin
      h_eff = FH_W'(HEIGHT_LIMIT);
    end else begin
      h_eff = frame_height_r;
    end
    total = TOTAL_W'(w_eff) * TOTAL_W'(h_eff);
  end

  // Handshakes
  assign s1_fire  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_fire;
  assign in_xfer  = in_valid && in_ready;

  // Column of the staged item, and the column of the item after it
  always_comb begin
    c_cur     = (CMP_W'(col_r) >= CMP_W'(w_eff)) ? '0 : col_r;
    c_inc     = CMP_W'(c_cur) + CMP_W'(1);
    c_wrap    = c_inc >= CMP_W'(w_eff);
    c_next_rd = c_wrap ? '0 : c_inc[ADDR_W-1:0];
    // A new item only enters alongside a staged one that is leaving
    rd_addr   = s1_valid_r ? c_next_rd : c_cur;
  end

  // Line stores: upper holds row r-2, middle holds row r-1
  plf_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
    .clk   (clk),
    .we    (s1_fire),
    .waddr (c_cur),
    .wdata (mid_rdata),
    .re    (in_xfer),
    .raddr (rd_addr),
    .rdata (up_rdata)
  );

  plf_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_middle (
    .clk   (clk),
    .we    (s1_fire),
    .waddr (c_cur),
    .wdata (ncol[2]),
    .re    (in_xfer),
    .raddr (rd_addr),
    .rdata (mid_rdata)
  );

  // New window column, with rows above the frame and past its end padded
  always_comb begin
    ncol[0] = (row_r >= ROW_W'(2)) ? up_rdata  : '0;
    ncol[1] = (row_r >= ROW_W'(1)) ? mid_rdata : '0;
    ncol[2] = ((s1_op_r == OP_PIXEL) && (row_r < h_eff)) ? s1_pixel_r : '0;
    emit    = (row_r >= ROW_W'(2)) || ((row_r == ROW_W'(1)) && (c_cur != '0));
    last    = (TOTAL_W'(emit_cnt_r) + TOTAL_W'(1)) >= total;
    kctl.col_first  = (c_cur == '0);
    kctl.col_second = (c_cur == ADDR_W'(1));
  end

  plf_kernel u_kernel (
    .win_left (win_a_r),
    .win_mid  (win_b_r),
    .new_col  (ncol),
    .ctl      (kctl),
    .res      (kres)
  );

  // Advance position, window and result count
  always_comb begin
    col_nxt      = col_r;
    row_nxt      = row_r;
    emit_cnt_nxt = emit_cnt_r;
    win_a_nxt    = win_a_r;
    win_b_nxt    = win_b_r;
    if (s1_fire) begin
      win_a_nxt = win_b_r;
      win_b_nxt = ncol;
      if (c_wrap) begin
        col_nxt = '0;
        if (row_r != '1) begin
          row_nxt = row_r + ROW_W'(1);
        end
      end else begin
        col_nxt = c_inc[ADDR_W-1:0];
      end
      if (emit) begin
        if (last) begin
          col_nxt      = '0;
          row_nxt      = '0;
          emit_cnt_nxt = '0;
          win_a_nxt    = '0;
          win_b_nxt    = '0;
        end else begin
          emit_cnt_nxt = emit_cnt_r + EMIT_W'(1);
        end
      end
    end
  end

  // Output valid: load on an emitting item, drop on transfer
  always_comb begin
    if (s1_fire && emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      col_r       <= '0;
      row_r       <= '0;
      emit_cnt_r  <= '0;
      win_a_r     <= '0;
      win_b_r     <= '0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      out_valid_r <= out_valid_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      emit_cnt_r  <= emit_cnt_nxt;
      win_a_r     <= win_a_nxt;
      win_b_r     <= win_b_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_op_r    <= in_op;
      s1_pixel_r <= in_pixel;
    end
    if (s1_fire && emit) begin
      out_vert_r  <= kres.vert;
      out_horiz_r <= kres.horiz;
      out_lap_r   <= kres.lap;
      out_last_r  <= last;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_vert_gradient  = out_vert_r;
  assign out_horiz_gradient = out_horiz_r;
  assign out_laplacian      = out_lap_r;
  assign out_last_of_frame  = out_last_r;

endmodule

`default_nettype wire

### rtl/plf_checker.sv
// ----------------------------------------------------------------------------
// plf_checker
// Port-level checks for the Prewitt / Laplacian 3x3 filter, bound to the
// top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "prewitt_laplacian_3x3_filter_assert.svh"

module plf_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic signed [plf_pkg::RES_W-1:0] out_vert_gradient,
  input logic signed [plf_pkg::RES_W-1:0] out_horiz_gradient,
  input logic signed [plf_pkg::RES_W-1:0] out_laplacian,
  input logic                             out_last_of_frame
);

  // Hold a stalled result
  `PLF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "out_valid dropped while stalled")
  `PLF_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_vert_gradient) && $stable(out_horiz_gradient) && $stable(out_laplacian) && $stable(out_last_of_frame), "result changed while stalled")

  // A free output side never blocks input
  `PLF_ASSERT_NOW(a_in_free, out_ready, in_ready, "in_ready low while out_ready high")

  // A new frame needs a row and a pixel before its first result
  `PLF_ASSERT_NEXT(a_frame_gap, out_valid && out_ready && out_last_of_frame, !out_valid, "result right after frame end")

  // Input side sanity: valid input with a stalled stage must be retried
  `PLF_ASSERT_NEXT(a_in_hold, in_valid && !in_ready, in_valid, "in_valid dropped before transfer")

endmodule

bind prewitt_laplacian_3x3_filter plf_checker u_plf_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_vert_gradient  (out_vert_gradient),
  .out_horiz_gradient (out_horiz_gradient),
  .out_laplacian      (out_laplacian),
  .out_last_of_frame  (out_last_of_frame)
);

`default_nettype wire

### tb/prewitt_laplacian_3x3_filter_tb.sv
// ----------------------------------------------------------------------------
// prewitt_laplacian_3x3_filter_tb
// Self-checking bench for the streaming 3x3 Prewitt / Laplacian filter. A
// queue-fed driver sends pixel and flush transfers with random gaps. A
// predictor with its own line stores and window computes the gradients of
// every accepted transfer. A monitor with random stalls compares each result
// field by field against the oldest prediction. Frame sizes go from the
// clamped minimum to the largest width and height; the largest ones are cut
// short by narrowing a register in mid-frame, as are two small frames.
// ----------------------------------------------------------------------------
module prewitt_laplacian_3x3_filter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import plf_pkg::*;

  localparam int          SETTLE_CYCLES     = 8;
  localparam int unsigned WATCHDOG_LIMIT    = 2000;
  localparam int unsigned RANDOM_ITEM_GOAL  = 1050;
  localparam int          LAP_CENTER_WEIGHT = -4;
  localparam int unsigned ROW_MAX           = (1 << ROW_W) - 1;
  localparam int unsigned EMIT_MASK         = (1 << EMIT_W) - 1;

  typedef struct packed {
    logic op;
    pix_t pixel;
  } pix_item_t;

  typedef struct packed {
    res_t vert;
    res_t horiz;
    res_t lap;
    logic last;
  } grad_set_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  logic                  in_op     = OP_PIXEL;
  pix_t                  in_pixel  = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  res_t                  out_vert_gradient;
  res_t                  out_horiz_gradient;
  res_t                  out_laplacian;
  logic                  out_last_of_frame;

  // Stimulus and expectation stores
  pix_item_t pixel_feed [$];
  grad_set_t expected_grads [$];

  // Predictor state
  logic [FW_W-1:0]                width_reg = FW_W'(WIDTH_RST);
  logic [FH_W-1:0]                height_reg = FH_W'(HEIGHT_RST);
  pix_t                           upper_line [MAX_WIDTH_DEF];
  pix_t                           middle_line [MAX_WIDTH_DEF];
  logic [2:0][2:0][PIX_W-1:0]     win = '0;
  int unsigned                    col_pos = 0;
  int unsigned                    row_pos = 0;
  int unsigned                    emit_cnt = 0;

  // Driver and monitor pacing
  logic        feed_busy = 1'b0;
  logic        feed_burst = 1'b0;
  int unsigned feed_gap = 0;
  logic        drain_burst = 1'b0;
  int unsigned drain_stall = 0;

  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles = 0;

  prewitt_laplacian_3x3_filter #(
    .MAX_WIDTH(MAX_WIDTH_DEF)
  ) u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_idx           (cfg_idx),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_op             (in_op),
    .in_pixel          (in_pixel),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_vert_gradient (out_vert_gradient),
    .out_horiz_gradient(out_horiz_gradient),
    .out_laplacian     (out_laplacian),
    .out_last_of_frame (out_last_of_frame)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Clamp the register values to the sizes the filter really uses
  function automatic int unsigned active_width();
    int unsigned w;
    w = width_reg;
    if (w < MIN_DIM) w = MIN_DIM;
    else if (w > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
    return w;
  endfunction

  function automatic int unsigned active_height();
    int unsigned h;
    h = height_reg;
    if (h < MIN_DIM) h = MIN_DIM;
    else if (h > HEIGHT_LIMIT) h = HEIGHT_LIMIT;
    return h;
  endfunction

  // Advance the window by one transfer and queue the gradients it yields
  task automatic compute_gradients(input logic op, input pix_t pix);
    int unsigned       w, h, c, r;
    logic [2:0][7:0]   ncol;
    int                p [0:2][0:2];
    int                vg, hg, lap;
    logic              emit;
    grad_set_t         g;
    w = active_width();
    h = active_height();
    if (col_pos >= w) col_pos = 0;
    c = col_pos;
    r = row_pos;
    ncol[2] = (op == OP_PIXEL && r < h) ? pix : '0;
    ncol[0] = (r >= 2) ? upper_line[c] : '0;
    ncol[1] = (r >= 1) ? middle_line[c] : '0;
    emit = (r >= 2) || (r == 1 && c >= 1);
    g = '0;
    if (emit) begin
      for (int k = 0; k < 3; k++) begin
        p[k][0] = (c == 1) ? 0 : int'(win[k][1]);
        p[k][1] = win[k][2];
        p[k][2] = (c == 0) ? 0 : int'(ncol[k]);
      end
      vg = (p[0][0] + p[1][0] + p[2][0]) - (p[0][2] + p[1][2] + p[2][2]);
      hg = (p[2][0] + p[2][1] + p[2][2]) - (p[0][0] + p[0][1] + p[0][2]);
      lap = p[0][1] + p[1][0] + p[1][2] + p[2][1] + LAP_CENTER_WEIGHT * p[1][1];
      g.vert  = vg[RES_W-1:0];
      g.horiz = hg[RES_W-1:0];
      g.lap   = lap[RES_W-1:0];
      g.last  = (emit_cnt + 1 >= w * h);
      expected_grads.push_back(g);
    end
    for (int k = 0; k < 3; k++) begin
      win[k][0] = win[k][1];
      win[k][1] = win[k][2];
      win[k][2] = ncol[k];
    end
    upper_line[c]  = middle_line[c];
    middle_line[c] = ncol[2];
    col_pos = c + 1;
    if (col_pos >= w) begin
      col_pos = 0;
      if (row_pos < ROW_MAX) row_pos++;
    end
    // Frame end: clear counters and window
    if (emit) begin
      if (g.last) begin
        col_pos  = 0;
        row_pos  = 0;
        emit_cnt = 0;
        win      = '0;
      end else begin
        emit_cnt = (emit_cnt + 1) & EMIT_MASK;
      end
    end
  endtask

  function automatic pix_t draw_luma();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      default: return pix_t'($urandom);
    endcase
  endfunction

  task automatic push_item(input logic op, input pix_t pix);
    pix_item_t it;
    it.op = op;
    it.pixel = pix;
    pixel_feed.push_back(it);
  endtask

  // Queue one frame; skew shifts the number of trailing, mostly flush, transfers
  task automatic queue_frame(input int skew, output int unsigned n);
    int unsigned w, h, tail;
    w = active_width();
    h = active_height();
    for (int unsigned i = 0; i < w * h; i++)
      push_item(($urandom_range(0, 19) == 0) ? OP_FLUSH : OP_PIXEL, draw_luma());
    tail = int'(w) + 1 + skew;
    for (int unsigned i = 0; i < tail; i++)
      push_item(($urandom_range(0, 9) == 0) ? OP_PIXEL : OP_FLUSH, draw_luma());
    n = w * h + tail;
  endtask

  task automatic wait_drained();
    while (pixel_feed.size() != 0 || feed_busy || expected_grads.size() != 0)
      @(posedge clk);
  endtask

  task automatic settle();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Pad with flush transfers until the filter is back at a frame start
  task automatic finish_frame();
    wait_drained();
    while (row_pos != 0 || col_pos != 0) begin
      push_item(OP_FLUSH, draw_luma());
      wait_drained();
    end
  endtask

  // Drive one register write; the caller drops cfg_we afterwards
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    if (idx == REG_FRAME_WIDTH) width_reg = data[FW_W-1:0];
    else height_reg = data[FH_W-1:0];
    @(posedge clk);
  endtask

  task automatic program_frame(input int unsigned w, input int unsigned h);
    logic [CFG_DATA_W-1:0] wdat;
    finish_frame();
    settle();
    // Upper data bits beyond the width register are don't-care
    wdat = CFG_DATA_W'($urandom);
    wdat[FW_W-1:0] = w[FW_W-1:0];
    write_reg(REG_FRAME_WIDTH, wdat);
    write_reg(REG_FRAME_HEIGHT, h[CFG_DATA_W-1:0]);
    cfg_we <= 1'b0;
  endtask

  // Stop inside a frame, rewrite one register, then run the frame out
  task automatic mid_frame_change(input int unsigned w, input int unsigned h,
                                  input int unsigned lead,
                                  input logic [CFG_IDX_W-1:0] idx,
                                  input int unsigned val);
    program_frame(w, h);
    repeat (lead) push_item(OP_PIXEL, draw_luma());
    wait_drained();
    settle();
    write_reg(idx, val[CFG_DATA_W-1:0]);
    cfg_we <= 1'b0;
    finish_frame();
  endtask

  // Feed transfers from the queue with random gaps
  always @(posedge clk) begin : drive_pixels
    pix_item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
      feed_busy = 1'b0;
      feed_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        compute_gradients(in_op, in_pixel);
        feed_busy = 1'b0;
      end
      if (!feed_busy) begin
        if (feed_gap != 0) begin
          feed_gap--;
        end else if (pixel_feed.size() != 0) begin
          nxt = pixel_feed.pop_front();
          in_op    <= nxt.op;
          in_pixel <= nxt.pixel;
          feed_busy = 1'b1;
          if ($urandom_range(0, 39) == 0) feed_burst = !feed_burst;
          feed_gap = feed_burst ? 0 : $urandom_range(0, 8);
        end
      end
      in_valid <= feed_busy;
    end
  end

  task automatic note_mismatch(input string what, input grad_set_t want,
                               input grad_set_t got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t %s: exp v=%0d h=%0d l=%0d last=%0b got v=%0d h=%0d l=%0d last=%0b",
               $realtime, what, want.vert, want.horiz, want.lap, want.last,
               got.vert, got.horiz, got.lap, got.last);
  endtask

  // Check each result transfer, stall at random
  always @(posedge clk) begin : check_results
    grad_set_t got, want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      drain_stall = 0;
    end else begin
      if (out_valid && out_ready) begin
        got.vert  = out_vert_gradient;
        got.horiz = out_horiz_gradient;
        got.lap   = out_laplacian;
        got.last  = out_last_of_frame;
        if (expected_grads.size() == 0) begin
          note_mismatch("result with nothing expected", '0, got);
        end else begin
          want = expected_grads.pop_front();
          if (got.vert !== want.vert || got.horiz !== want.horiz ||
              got.lap !== want.lap || got.last !== want.last)
            note_mismatch("result mismatch", want, got);
        end
        if ($urandom_range(0, 39) == 0) drain_burst = !drain_burst;
        drain_stall = drain_burst ? 0 : $urandom_range(0, 8);
      end else if (drain_stall != 0) begin
        drain_stall--;
      end
      out_ready <= (drain_stall == 0);
    end
  end

  // Abort when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : run_frames
    int unsigned random_items, n, w, h;
    int skew;
    random_items = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Smallest frame from clamped register values: checkerboard
    program_frame(0, 1);
    for (int i = 0; i < 9; i++) push_item(OP_PIXEL, (i % 2) ? 8'd255 : 8'd0);
    repeat (4) push_item(OP_FLUSH, 8'd0);
    // Top row of flushes carrying a pixel, then pixels in the padding rows
    repeat (3) push_item(OP_FLUSH, 8'd255);
    push_item(OP_PIXEL, 8'd0);
    push_item(OP_PIXEL, 8'd255);
    push_item(OP_PIXEL, 8'd0);
    repeat (3) push_item(OP_PIXEL, 8'd255);
    repeat (4) push_item(OP_PIXEL, 8'd255);

    // Narrow width, then height, while a frame is open
    mid_frame_change(12, 10, 44, REG_FRAME_WIDTH, 5);
    mid_frame_change(6, 9, 32, REG_FRAME_HEIGHT, 4);

    // Largest width and largest height from out-of-range values, cut short
    mid_frame_change(511, 3, 300, REG_FRAME_WIDTH, 8);
    mid_frame_change(3, 2047, 30, REG_FRAME_HEIGHT, 4);

    // Random frame sizes, occasionally with a wrong flush count
    while (random_items < RANDOM_ITEM_GOAL) begin
      case ($urandom_range(0, 9))
        0:       w = $urandom_range(0, 2);
        1:       w = $urandom_range(17, 40);
        default: w = $urandom_range(3, 16);
      endcase
      case ($urandom_range(0, 9))
        0:       h = $urandom_range(0, 2);
        1:       h = $urandom_range(9, 20);
        default: h = $urandom_range(3, 8);
      endcase
      program_frame(w, h);
      repeat ($urandom_range(1, 3)) begin
        skew = ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, 4)) - 2 : 0;
        queue_frame(skew, n);
        random_items += n;
      end
    end

    finish_frame();
    settle();
    if (mismatch_count == 0 && expected_grads.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
